@@ sv/pcsc_pkg.sv @@
// Shared types, constants and helper functions for the pixel color space converter.
// No dependencies; every other file of the block imports this package.

package pcsc_pkg;

    // Operating modes of the converter, as written to the mode register.
    typedef enum logic [2:0] {
        MODE_YCBCR    = 3'd0,
        MODE_Y_GREY   = 3'd1,
        MODE_CB_GREY  = 3'd2,
        MODE_CR_GREY  = 3'd3,
        MODE_TO_RGB   = 3'd4
    } mode_t;

    localparam int MODE_W = 3;
    localparam int BYTE_W = 8;

    // Conversion weights in units of 1/10000.
    localparam longint K_YR  = 2990;
    localparam longint K_YG  = 5870;
    localparam longint K_YB  = 1140;
    localparam longint K_CB  = 5643;
    localparam longint K_CR  = 7132;
    localparam longint K_RCR = 14020;
    localparam longint K_GCR = 7140;
    localparam longint K_GCB = 3340;
    localparam longint K_BCB = 17720;

    // Advance enables for the four pipeline stages.
    typedef struct packed {
        logic st1;
        logic st2;
        logic st3;
        logic st4;
    } pipe_en_t;

    // Weight in 1/10000 units turned into a fixed-point coefficient with fb fraction
    // bits, rounded to nearest with halves rounded up.
    function automatic longint coef_q(input longint k, input int fb);
        return (k * (longint'(1) << fb) + 64'sd5000) / 64'sd10000;
    endfunction

    // Saturate a floored signed value (integer part, 12 bits) to the range 0..255.
    function automatic logic [7:0] sat_u8(input logic [11:0] v);
        logic [7:0] res;
        if (v[11]) begin
            res = 8'd0;
        end else if (|v[10:8]) begin
            res = 8'hFF;
        end else begin
            res = v[7:0];
        end
        return res;
    endfunction

endpackage

@@ sv/pcsc_front.sv @@
// Front half of the converter pipeline: coefficient products (stage 1) and their sums (stage 2).
// Forms the fixed-point luma for the forward path and the full sums of the inverse path.
// Depends on pcsc_pkg.

module pcsc_front
    import pcsc_pkg::*;
#(
    parameter int COEF_FRAC_BITS = 16
) (
    input  logic                          aclk,
    input  pipe_en_t                      en,
    input  logic [7:0]                    in_slot0,
    input  logic [7:0]                    in_slot1,
    input  logic [7:0]                    in_slot2,
    output logic [COEF_FRAC_BITS+8:0]     yq,
    output logic [7:0]                    blue,
    output logic [7:0]                    red,
    output logic signed [COEF_FRAC_BITS+11:0] r_sum,
    output logic signed [COEF_FRAC_BITS+11:0] g_sum,
    output logic signed [COEF_FRAC_BITS+11:0] b_sum
);

    localparam int F  = COEF_FRAC_BITS;
    localparam int SW = F + 12;

    localparam logic [F-1:0] C_YR  = F'(coef_q(K_YR, F));
    localparam logic [F-1:0] C_YG  = F'(coef_q(K_YG, F));
    localparam logic [F-1:0] C_YB  = F'(coef_q(K_YB, F));
    localparam logic [F:0]   C_RCR = (F+1)'(coef_q(K_RCR, F));
    localparam logic [F:0]   C_GCR = (F+1)'(coef_q(K_GCR, F));
    localparam logic [F:0]   C_GCB = (F+1)'(coef_q(K_GCB, F));
    localparam logic [F:0]   C_BCB = (F+1)'(coef_q(K_BCB, F));

    // Stage 1 registers.
    logic [F+7:0]         pyr_reg, pyg_reg, pyb_reg;
    logic signed [F+10:0] prcr_reg, pgcr_reg, pgcb_reg, pbcb_reg;
    logic [7:0]           s0_1_reg, s1_1_reg, s2_1_reg;

    // Stage 2 registers.
    logic [F+8:0]         yq_reg;
    logic signed [SW-1:0] r_sum_reg, g_sum_reg, b_sum_reg;
    logic [7:0]           s0_2_reg, s2_2_reg;

    logic signed [8:0]    dcr, dcb;
    logic signed [F+10:0] prcr_next, pgcr_next, pgcb_next, pbcb_next;
    logic [F+8:0]         yq_next;
    logic signed [SW-1:0] y_base;
    logic signed [SW-1:0] r_sum_next, g_sum_next, b_sum_next;

    // Stage 1: chroma offsets and all products.
    always_comb begin
        dcr       = $signed({1'b0, in_slot0}) - 9'sd128;
        dcb       = $signed({1'b0, in_slot2}) - 9'sd128;
        prcr_next = $signed({1'b0, C_RCR}) * dcr;
        pgcr_next = $signed({1'b0, C_GCR}) * dcr;
        pgcb_next = $signed({1'b0, C_GCB}) * dcb;
        pbcb_next = $signed({1'b0, C_BCB}) * dcb;
    end

    always_ff @(posedge aclk) begin
        if (en.st1) begin
            pyr_reg  <= C_YR * in_slot2;
            pyg_reg  <= C_YG * in_slot1;
            pyb_reg  <= C_YB * in_slot0;
            prcr_reg <= prcr_next;
            pgcr_reg <= pgcr_next;
            pgcb_reg <= pgcb_next;
            pbcb_reg <= pbcb_next;
            s0_1_reg <= in_slot0;
            s1_1_reg <= in_slot1;
            s2_1_reg <= in_slot2;
        end
    end

    // Stage 2: luma sum and the three inverse sums.
    always_comb begin
        yq_next    = (F+9)'(pyr_reg) + (F+9)'(pyg_reg) + (F+9)'(pyb_reg);
        y_base     = $signed(SW'({s1_1_reg, {F{1'b0}}}));
        r_sum_next = y_base + SW'(prcr_reg);
        g_sum_next = y_base - SW'(pgcr_reg) - SW'(pgcb_reg);
        b_sum_next = y_base + SW'(pbcb_reg);
    end

    always_ff @(posedge aclk) begin
        if (en.st2) begin
            yq_reg    <= yq_next;
            r_sum_reg <= r_sum_next;
            g_sum_reg <= g_sum_next;
            b_sum_reg <= b_sum_next;
            s0_2_reg  <= s0_1_reg;
            s2_2_reg  <= s2_1_reg;
        end
    end

    assign yq    = yq_reg;
    assign blue  = s0_2_reg;
    assign red   = s2_2_reg;
    assign r_sum = r_sum_reg;
    assign g_sum = g_sum_reg;
    assign b_sum = b_sum_reg;

endmodule

@@ sv/pcsc_back.sv @@
// Back half of the converter pipeline: chroma products (stage 3) and final rounding,
// saturation and mode selection into the output register (stage 4).
// Depends on pcsc_pkg.

module pcsc_back
    import pcsc_pkg::*;
#(
    parameter int COEF_FRAC_BITS = 16
) (
    input  logic                              aclk,
    input  pipe_en_t                          en,
    input  logic [MODE_W-1:0]                 mode,
    input  logic [COEF_FRAC_BITS+8:0]         yq,
    input  logic [7:0]                        blue,
    input  logic [7:0]                        red,
    input  logic signed [COEF_FRAC_BITS+11:0] r_sum,
    input  logic signed [COEF_FRAC_BITS+11:0] g_sum,
    input  logic signed [COEF_FRAC_BITS+11:0] b_sum,
    output logic [7:0]                        out_slot0,
    output logic [7:0]                        out_slot1,
    output logic [7:0]                        out_slot2
);

    localparam int F  = COEF_FRAC_BITS;
    localparam int QW = 2 * F + 12;

    localparam logic [F-1:0]  C_CB = F'(coef_q(K_CB, F));
    localparam logic [F-1:0]  C_CR = F'(coef_q(K_CR, F));
    localparam logic [QW-1:0] HALF = QW'(1) << (2 * F + 7);

    // Stage 3 registers.
    logic signed [F+10:0] pcb_hi_reg, pcr_hi_reg;
    logic [2*F-1:0]       pcb_lo_reg, pcr_lo_reg;
    logic [7:0]           y_byte_reg;
    logic [7:0]           inv_r_reg, inv_g_reg, inv_b_reg;

    // Stage 4 (output) registers.
    logic [7:0] slot0_reg, slot1_reg, slot2_reg;

    logic [8:0]           y_hi;
    logic [F-1:0]         y_lo;
    logic signed [9:0]    db, dr;
    logic signed [F+10:0] pcb_hi_next, pcr_hi_next;
    logic signed [QW-1:0] cbq, crq;
    logic [7:0]           cb_byte, cr_byte;
    logic [7:0]           slot0_next, slot1_next, slot2_next;

    // Stage 3: split luma into integer and fraction so each product stays narrow.
    always_comb begin
        y_hi        = yq[F+8:F];
        y_lo        = yq[F-1:0];
        db          = $signed({2'b00, blue}) - $signed({1'b0, y_hi});
        dr          = $signed({2'b00, red}) - $signed({1'b0, y_hi});
        pcb_hi_next = $signed({1'b0, C_CB}) * db;
        pcr_hi_next = $signed({1'b0, C_CR}) * dr;
    end

    always_ff @(posedge aclk) begin
        if (en.st3) begin
            pcb_hi_reg <= pcb_hi_next;
            pcr_hi_reg <= pcr_hi_next;
            pcb_lo_reg <= C_CB * y_lo;
            pcr_lo_reg <= C_CR * y_lo;
            y_byte_reg <= sat_u8({3'b000, y_hi});
            inv_r_reg  <= sat_u8(r_sum[F+11:F]);
            inv_g_reg  <= sat_u8(g_sum[F+11:F]);
            inv_b_reg  <= sat_u8(b_sum[F+11:F]);
        end
    end

    // Stage 4: reassemble chroma, floor and saturate.
    always_comb begin
        cbq = $signed({pcb_hi_reg[F+10], pcb_hi_reg, {F{1'b0}}})
            - $signed({12'd0, pcb_lo_reg}) + $signed(HALF);
        crq = $signed({pcr_hi_reg[F+10], pcr_hi_reg, {F{1'b0}}})
            - $signed({12'd0, pcr_lo_reg}) + $signed(HALF);
        cb_byte = sat_u8(cbq[QW-1:2*F]);
        cr_byte = sat_u8(crq[QW-1:2*F]);
    end

    // Output selection by mode; unused mode codes give zero bytes.
    always_comb begin
        unique case (mode)
            MODE_YCBCR: begin
                slot0_next = cr_byte;
                slot1_next = y_byte_reg;
                slot2_next = cb_byte;
            end
            MODE_Y_GREY: begin
                slot0_next = y_byte_reg;
                slot1_next = y_byte_reg;
                slot2_next = y_byte_reg;
            end
            MODE_CB_GREY: begin
                slot0_next = cb_byte;
                slot1_next = cb_byte;
                slot2_next = cb_byte;
            end
            MODE_CR_GREY: begin
                slot0_next = cr_byte;
                slot1_next = cr_byte;
                slot2_next = cr_byte;
            end
            MODE_TO_RGB: begin
                slot0_next = inv_b_reg;
                slot1_next = inv_g_reg;
                slot2_next = inv_r_reg;
            end
            default: begin
                slot0_next = 8'd0;
                slot1_next = 8'd0;
                slot2_next = 8'd0;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (en.st4) begin
            slot0_reg <= slot0_next;
            slot1_reg <= slot1_next;
            slot2_reg <= slot2_next;
        end
    end

    assign out_slot0 = slot0_reg;
    assign out_slot1 = slot1_reg;
    assign out_slot2 = slot2_reg;

endmodule

@@ sv/pixel_color_space_converter_core.sv @@
// Pixel color space converter: RGB to YCbCr, grey planes, and YCbCr back to RGB.
// A request accepted into stage 1 moves through stages 2, 3 and 4 and is then valid on the
// m_ side. Throughput is one pixel per cycle unless m_tready stalls it, set by the four-stage
// multiply/add pipeline. Each stage holds its data under stall and takes a new request
// whenever it is empty. Reset (aresetn low, synchronous) empties the pipeline, holds
// s_tready low and sets mode to 0.
// Depends on pcsc_pkg, pcsc_front and pcsc_back.

module pixel_color_space_converter_core
    import pcsc_pkg::*;
#(
    parameter int COEF_FRAC_BITS = 16
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_wr_en,
    input  logic [2:0]  cfg_wr_data,   // mode
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [23:0] s_tdata,       // in_slot0 [7:0], in_slot1 [15:8], in_slot2 [23:16]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [23:0] m_tdata        // out_slot0 [7:0], out_slot1 [15:8], out_slot2 [23:16]
);

    localparam int F = COEF_FRAC_BITS;

    logic [MODE_W-1:0] mode_reg, mode_next;
    logic v1_reg, v2_reg, v3_reg, v4_reg;
    logic v1_next, v2_next, v3_next, v4_next;
    pipe_en_t en;

    logic [F+8:0]          yq;
    logic [7:0]            blue, red;
    logic signed [F+11:0]  r_sum, g_sum, b_sum;
    logic [7:0]            out_slot0, out_slot1, out_slot2;

    // Mode register; the user must write it only while the pipeline is empty, the block does not enforce this.
    assign mode_next = cfg_wr_en ? cfg_wr_data : mode_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg <= MODE_YCBCR;
        end else begin
            mode_reg <= mode_next;
        end
    end

    // A stage advances when it is empty or the stage after it advances.
    always_comb begin
        en.st4 = !v4_reg || m_tready;
        en.st3 = !v3_reg || en.st4;
        en.st2 = !v2_reg || en.st3;
        en.st1 = !v1_reg || en.st2;
    end

    // No request is taken while reset is held.
    assign s_tready = en.st1 && aresetn;

    always_comb begin
        v1_next = en.st1 ? s_tvalid : v1_reg;
        v2_next = en.st2 ? v1_reg   : v2_reg;
        v3_next = en.st3 ? v2_reg   : v3_reg;
        v4_next = en.st4 ? v3_reg   : v4_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
        end else begin
            v1_reg <= v1_next;
            v2_reg <= v2_next;
            v3_reg <= v3_next;
            v4_reg <= v4_next;
        end
    end

    // Products and sums.
    pcsc_front #(
        .COEF_FRAC_BITS (COEF_FRAC_BITS)
    ) u_front (
        .aclk      (aclk),
        .en        (en),
        .in_slot0  (s_tdata[7:0]),
        .in_slot1  (s_tdata[15:8]),
        .in_slot2  (s_tdata[23:16]),
        .yq        (yq),
        .blue      (blue),
        .red       (red),
        .r_sum     (r_sum),
        .g_sum     (g_sum),
        .b_sum     (b_sum)
    );

    // Chroma, saturation and output register.
    pcsc_back #(
        .COEF_FRAC_BITS (COEF_FRAC_BITS)
    ) u_back (
        .aclk      (aclk),
        .en        (en),
        .mode      (mode_reg),
        .yq        (yq),
        .blue      (blue),
        .red       (red),
        .r_sum     (r_sum),
        .g_sum     (g_sum),
        .b_sum     (b_sum),
        .out_slot0 (out_slot0),
        .out_slot1 (out_slot1),
        .out_slot2 (out_slot2)
    );

    assign m_tvalid = v4_reg;
    assign m_tdata  = {out_slot2, out_slot1, out_slot0};

endmodule

@@ test/pixel_color_space_converter_core_test.sv @@
// Testbench for pixel_color_space_converter_core: directed and random pixel requests in
// every mode, checked field by field against a fixed-point predictor held here.
// Depends on pcsc_pkg and the converter RTL; reads no files.
`timescale 1ns / 100ps

module pixel_color_space_converter_core_test
    import pcsc_pkg::*;
;

    // Pixel bytes; slot0 sits in the lowest bits of tdata.
    typedef struct packed {
        logic [7:0] slot2;
        logic [7:0] slot1;
        logic [7:0] slot0;
    } pixel_t;

    // One row of the directed table; the result is only used when typed is set.
    typedef struct packed {
        logic [2:0] mode;
        logic       typed;
        pixel_t     px;
        pixel_t     result;
    } plan_row_t;

    // Mode values that the package leaves unnamed; they must give all-zero pixels.
    localparam logic [2:0] MODE_SPARE5 = 3'd5;
    localparam logic [2:0] MODE_SPARE6 = 3'd6;
    localparam logic [2:0] MODE_SPARE7 = 3'd7;

    localparam int FRAC         = 16;
    localparam int PIPE_LATENCY = 4;
    localparam int SETTLE       = PIPE_LATENCY + 4;
    localparam int IDLE_LIMIT   = 2000;
    localparam int PHASE_ITEMS  = 175;

    // Q16 weights, rounded to nearest from units of 1/10000.
    localparam longint ONE   = longint'(1) << FRAC;
    localparam longint HALF  = longint'(128) << (2 * FRAC);
    localparam longint W_YR  = (64'sd2990 * ONE + 64'sd5000) / 64'sd10000;
    localparam longint W_YG  = (64'sd5870 * ONE + 64'sd5000) / 64'sd10000;
    localparam longint W_YB  = (64'sd1140 * ONE + 64'sd5000) / 64'sd10000;
    localparam longint W_CB  = (64'sd5643 * ONE + 64'sd5000) / 64'sd10000;
    localparam longint W_CR  = (64'sd7132 * ONE + 64'sd5000) / 64'sd10000;
    localparam longint W_RCR = (64'sd14020 * ONE + 64'sd5000) / 64'sd10000;
    localparam longint W_GCR = (64'sd7140 * ONE + 64'sd5000) / 64'sd10000;
    localparam longint W_GCB = (64'sd3340 * ONE + 64'sd5000) / 64'sd10000;
    localparam longint W_BCB = (64'sd17720 * ONE + 64'sd5000) / 64'sd10000;

    // Directed pixels: black and white, primaries, clamping both ways, unused modes.
    localparam int PLAN_ROWS = 23;
    localparam plan_row_t DIRECTED_PLAN [PLAN_ROWS] = '{
        '{MODE_YCBCR,   1'b1, 24'h000000, 24'h800080},
        '{MODE_YCBCR,   1'b1, 24'hFFFFFF, 24'h80FF80},
        '{MODE_YCBCR,   1'b0, 24'hFF0000, 24'h000000},
        '{MODE_YCBCR,   1'b0, 24'h0000FF, 24'h000000},
        '{MODE_YCBCR,   1'b0, 24'h00FF00, 24'h000000},
        '{MODE_YCBCR,   1'b0, 24'h808080, 24'h000000},
        '{MODE_Y_GREY,  1'b1, 24'hFFFFFF, 24'hFFFFFF},
        '{MODE_Y_GREY,  1'b1, 24'h000000, 24'h000000},
        '{MODE_Y_GREY,  1'b0, 24'h123456, 24'h000000},
        '{MODE_CB_GREY, 1'b1, 24'h000000, 24'h808080},
        '{MODE_CB_GREY, 1'b0, 24'h0000FF, 24'h000000},
        '{MODE_CR_GREY, 1'b1, 24'h000000, 24'h808080},
        '{MODE_CR_GREY, 1'b0, 24'hFF0000, 24'h000000},
        '{MODE_TO_RGB,  1'b1, 24'h800080, 24'h000000},
        '{MODE_TO_RGB,  1'b1, 24'h80FF80, 24'hFFFFFF},
        '{MODE_TO_RGB,  1'b0, 24'hFFFFFF, 24'h000000},
        '{MODE_TO_RGB,  1'b0, 24'h000000, 24'h000000},
        '{MODE_TO_RGB,  1'b0, 24'hFF00FF, 24'h000000},
        '{MODE_TO_RGB,  1'b0, 24'h00FF00, 24'h000000},
        '{MODE_SPARE5,  1'b1, 24'hFFFFFF, 24'h000000},
        '{MODE_SPARE6,  1'b1, 24'h5A5AA5, 24'h000000},
        '{MODE_SPARE7,  1'b1, 24'hFFFFFF, 24'h000000},
        '{MODE_SPARE7,  1'b1, 24'h000000, 24'h000000}
    };

    localparam int PHASES = 10;
    localparam logic [2:0] PHASE_MODES [PHASES] = '{
        MODE_TO_RGB, MODE_YCBCR, MODE_SPARE7, MODE_Y_GREY, MODE_CB_GREY,
        MODE_CR_GREY, MODE_SPARE5, MODE_YCBCR, MODE_TO_RGB, MODE_SPARE6
    };

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        cfg_wr_en = 1'b0;
    logic [2:0]  cfg_wr_data = 3'd0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [23:0] s_tdata = 24'd0;   // in_slot0 [7:0], in_slot1 [15:8], in_slot2 [23:16]
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [23:0] m_tdata;           // out_slot0 [7:0], out_slot1 [15:8], out_slot2 [23:16]

    pixel_t     expected_pixels [$];
    logic [2:0] cur_mode = MODE_YCBCR;
    int         error_count = 0;
    int         results_seen = 0;
    int         idle_cycles = 0;
    bit         s_steady = 1'b0;
    bit         m_steady = 1'b0;
    int         m_stall = 0;

    always #6 aclk = ~aclk;

    pixel_color_space_converter_core #(
        .COEF_FRAC_BITS(FRAC)
    ) DUT (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata)
    );

    // Floor a fixed-point value and saturate it to a byte; negatives are never shifted.
    function automatic logic [7:0] floor_clamp(input longint v, input int sh);
        longint u;
        if (v < 0) begin
            return 8'd0;
        end
        u = v >>> sh;
        if (u > 255) begin
            return 8'hFF;
        end
        return u[7:0];
    endfunction

    // Expected converted pixel for one request under the given mode.
    function automatic pixel_t convert_pixel(input pixel_t px, input logic [2:0] mode_sel);
        longint s0, s1, s2, luma_q, cb_q, cr_q, dcr, dcb;
        logic [7:0] y, cb, cr;
        pixel_t res;
        s0 = px.slot0;
        s1 = px.slot1;
        s2 = px.slot2;
        res = '0;
        // Forward direction: slot0 is blue, slot1 green, slot2 red.
        luma_q = W_YR * s2 + W_YG * s1 + W_YB * s0;
        cb_q = W_CB * (s0 * ONE - luma_q) + HALF;
        cr_q = W_CR * (s2 * ONE - luma_q) + HALF;
        y  = floor_clamp(luma_q, FRAC);
        cb = floor_clamp(cb_q, 2 * FRAC);
        cr = floor_clamp(cr_q, 2 * FRAC);
        case (mode_sel)
            MODE_YCBCR: begin
                res = '{cb, y, cr};
            end
            MODE_Y_GREY: begin
                res = '{y, y, y};
            end
            MODE_CB_GREY: begin
                res = '{cb, cb, cb};
            end
            MODE_CR_GREY: begin
                res = '{cr, cr, cr};
            end
            MODE_TO_RGB: begin
                // Inverse: slot0 is Cr, slot1 Y, slot2 Cb; result is B, G, R.
                dcr = s0 - 128;
                dcb = s2 - 128;
                res.slot2 = floor_clamp(s1 * ONE + W_RCR * dcr, FRAC);
                res.slot1 = floor_clamp(s1 * ONE - W_GCR * dcr - W_GCB * dcb, FRAC);
                res.slot0 = floor_clamp(s1 * ONE + W_BCB * dcb, FRAC);
            end
            default: begin
                res = '0;
            end
        endcase
        return res;
    endfunction

    // Random pixel: mostly uniform, some with extreme bytes, some close to neutral.
    function automatic pixel_t draw_pixel(input logic [2:0] mode_sel);
        logic [31:0] r;
        int kind, base;
        pixel_t px;
        r = $urandom;
        px = r[23:0];
        kind = $urandom_range(0, 9);
        if (kind >= 6 && kind <= 7) begin
            for (int i = 0; i < 3; i++) begin
                case ($urandom_range(0, 2))
                    0: px[8*i +: 8] = 8'h00;
                    1: px[8*i +: 8] = 8'hFF;
                    default: ;
                endcase
            end
        end else if (kind >= 8) begin
            if (mode_sel == MODE_TO_RGB) begin
                // Chroma near zero, luma anywhere.
                px.slot0 = 8'(120 + $urandom_range(0, 16));
                px.slot2 = 8'(120 + $urandom_range(0, 16));
            end else begin
                // Nearly grey input.
                base = $urandom_range(4, 251);
                for (int i = 0; i < 3; i++) begin
                    px[8*i +: 8] = 8'(base + $urandom_range(0, 8) - 4);
                end
            end
        end
        return px;
    endfunction

    // Length of one idle stretch: mostly short, a few long.
    function automatic int idle_span();
        int pick;
        pick = $urandom_range(0, 99);
        if (pick < 70) begin
            return $urandom_range(1, 2);
        end else if (pick < 95) begin
            return $urandom_range(3, 8);
        end
        return $urandom_range(15, 50);
    endfunction

    task automatic flag_error(input string msg);
        $display("ERROR at %0t ns: %s", $time, msg);
        error_count++;
    endtask

    // Offer one pixel request, wait for it to be taken and record what should come back.
    task automatic send_pixel(input pixel_t px, input logic typed, input pixel_t typed_result);
        int idle;
        pixel_t want_px;
        idle = (s_steady || $urandom_range(0, 2) != 0) ? 0 : idle_span();
        if (idle != 0) begin
            s_tvalid <= 1'b0;
            repeat (idle) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= px;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        want_px = typed ? typed_result : convert_pixel(px, cur_mode);
        expected_pixels = {expected_pixels, want_px};
    endtask

    // Hold the sender until every expected result has come back, then let the pipe settle.
    task automatic wait_drained();
        s_tvalid <= 1'b0;
        while (expected_pixels.size() != 0) @(posedge aclk);
        repeat (SETTLE) @(posedge aclk);
    endtask

    // Mode writes happen only with the converter empty.
    task automatic set_mode(input logic [2:0] mode_sel);
        wait_drained();
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= mode_sel;
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
        cur_mode = mode_sel;
    endtask

    // Result side: random backpressure with occasional stretches of none.
    always @(posedge aclk) begin
        if (m_stall != 0) begin
            m_stall  <= m_stall - 1;
            m_tready <= 1'b0;
        end else if (!m_steady && $urandom_range(0, 2) == 0) begin
            m_stall  <= idle_span() - 1;
            m_tready <= 1'b0;
        end else begin
            m_tready <= 1'b1;
        end
        if ($urandom_range(0, 199) == 0) begin
            m_steady <= !m_steady;
        end
    end

    // Compare every accepted result with the oldest expectation.
    always @(posedge aclk) begin : check_results
        pixel_t want;
        if (aresetn && m_tvalid && m_tready) begin
            results_seen++;
            if (expected_pixels.size() == 0) begin
                flag_error($sformatf("result %0d (%h) arrived with nothing expected",
                                     results_seen, m_tdata));
            end else begin
                want = expected_pixels.pop_front();
                for (int i = 0; i < 3; i++) begin
                    if (m_tdata[8*i +: 8] !== want[8*i +: 8]) begin
                        flag_error($sformatf("result %0d slot%0d: got %0d, want %0d (mode %0d)",
                                             results_seen, i, m_tdata[8*i +: 8],
                                             want[8*i +: 8], cur_mode));
                    end
                end
            end
        end
    end

    // Watchdog: too long without any request moving on either side.
    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
        if (idle_cycles >= IDLE_LIMIT) begin
            $display("Watchdog: no request accepted for %0d cycles", IDLE_LIMIT);
            $display("== FAIL ==");
            $finish;
        end
    end

    // Stimulus: directed table first, starting in the reset mode, then random phases per mode.
    initial begin
        int pause_at;
        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        for (int n = 0; n < PLAN_ROWS; n++) begin
            if (DIRECTED_PLAN[n].mode != cur_mode) begin
                set_mode(DIRECTED_PLAN[n].mode);
            end
            send_pixel(DIRECTED_PLAN[n].px, DIRECTED_PLAN[n].typed, DIRECTED_PLAN[n].result);
        end

        for (int p = 0; p < PHASES; p++) begin
            set_mode(PHASE_MODES[p]);
            pause_at = $urandom_range(20, PHASE_ITEMS - 20);
            for (int k = 0; k < PHASE_ITEMS; k++) begin
                if (k % 64 == 0) begin
                    s_steady = ($urandom_range(0, 3) == 0);
                end
                if (k == pause_at) begin
                    wait_drained();
                end
                send_pixel(draw_pixel(cur_mode), 1'b0, '0);
            end
        end

        // Let every result come home, then watch for strays.
        wait_drained();
        repeat (4 * PIPE_LATENCY) @(posedge aclk);
        if (error_count == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule
